// ----- rtl/core/mco_pkg.sv -----
// Shared types and constants for the motor current observer.
// No dependencies; imported by every module of the block.
package mco_pkg;

	// shared multiplier: signed operand and product widths
	localparam int MUL_OPW = 34;
	localparam int MUL_PW  = 2 * MUL_OPW;

	// divider: magnitude width of the numerator, divisor width
	localparam int DIV_NW = 61;
	localparam int DIV_DW = 24;

	// item function codes
	localparam logic [1:0] FN_PREDICT = 2'd0;
	localparam logic [1:0] FN_CORRECT = 2'd1;
	localparam logic [1:0] FN_CLEAR   = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_RESISTANCE = 3'd0;
	localparam logic [2:0] REG_INDUCTANCE = 3'd1;
	localparam logic [2:0] REG_FLUX       = 3'd2;
	localparam logic [2:0] REG_CUR_GAIN   = 3'd3;
	localparam logic [2:0] REG_EMF_GAIN   = 3'd4;

	// fixed-point constants
	localparam logic [15:0] DECAY_Q16      = 16'd62259;
	localparam logic [29:0] INV_SQRT3_Q30  = 30'd619925131;
	localparam logic [29:0] HALF_SQRT3_Q30 = 30'd929887697;
	localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
	localparam logic [31:0] SIN_C0         = 32'd172272;
	localparam logic [31:0] SIN_C1         = 32'd5026995;
	localparam logic [31:0] SIN_C2         = 32'd85569306;
	localparam logic [31:0] SIN_C3         = 32'd693598668;
	localparam logic [31:0] SIN_C4         = 32'd1686629713;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SIN_PREP,
		ST_SIN_X2,
		ST_SIN_X2W,
		ST_SIN_PM,
		ST_SIN_PW,
		ST_SIN_FX,
		ST_SIN_FW,
		ST_EMF,
		ST_EMF_A,
		ST_EMF_B,
		ST_PR_RI,
		ST_PR_DF,
		ST_PR_M1,
		ST_PR_M2,
		ST_PR_M3,
		ST_PR_DIV,
		ST_DECAY,
		ST_DECAY_W,
		ST_CO,
		ST_CO_MB,
		ST_CO_CA,
		ST_CO_CB,
		ST_CO_EA,
		ST_CO_EB,
		ST_CO_END,
		ST_IC,
		ST_IC_W,
		ST_DONE
	} mco_state_t;

endpackage

// ----- rtl/core/mco_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on mco_pkg for operand and product widths.
module mco_mul import mco_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_OPW-1:0] a,
	input  logic signed [MUL_OPW-1:0] b,
	output logic signed [MUL_PW-1:0]  p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

// ----- rtl/core/mco_div.sv -----
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// Depends on mco_pkg for the numerator and divisor widths.
module mco_div import mco_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DIV_NW:0]  num,
	input  logic [DIV_DW-1:0]       den,
	output logic                    done,
	output logic signed [DIV_NW:0]  quot
);

	localparam int CW = $clog2(DIV_NW + 1);

	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_NW-1:0] mag_q;
	logic [DIV_DW-1:0] rem_q;
	logic              neg_q;
	logic [DIV_NW:0]   num_neg;
	logic [DIV_DW:0]   trial;
	logic              ge;

	assign num_neg = -num;
	assign trial   = {rem_q, mag_q[DIV_NW-1]};
	assign ge      = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[DIV_NW] ? num_neg[DIV_NW-1:0] : num[DIV_NW-1:0];
			neg_q <= num[DIV_NW];
			rem_q <= '0;
		end else if (busy_q) begin
			// shift in the next numerator bit, subtract when it fits
			rem_q <= ge ? DIV_DW'(trial - {1'b0, den}) : trial[DIV_DW-1:0];
			mag_q <= {mag_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

// ----- rtl/core/motor_current_observer_unit.sv -----
// Alpha/beta current observer: sequencer, state and datapath around one multiplier.
// Depends on mco_pkg, mco_mul and mco_div.
//
// Usage:
//   Input channel (in_valid/in_stall) takes one transaction per item: func selects
//   predict, correct or clear; the other fields are read as the function needs.
//   Output channel (out_valid/out_stall) returns one transaction per item with the
//   current estimates, the inverse-Clarke phase currents and the confidence.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data); write
//   only while no transaction is in flight.
// Sequencing:
//   Every product goes through the single shared multiplier. A predict item
//   spends most of its time in the divider, one quotient bit per cycle, for each
//   axis. The next transaction can be taken in the cycle after the result is loaded.
//   in_stall is high from acceptance until the result is loaded into the output
//   register, so one item is worked on at a time.
// Reset:
//   arst_n clears the state, configuration, estimates and confidence; no sweep follows.
// Output stall:
//   The result holds in the output register while out_stall is high; a finished
//   next item waits in its last step until the register frees up.
module motor_current_observer_unit import mco_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] volt_alpha,
	input  logic [31:0] volt_beta,
	input  logic [15:0] angle,
	input  logic [19:0] step_ns,
	input  logic [31:0] meas_u,
	input  logic [31:0] meas_v,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] est_alpha,
	output logic [31:0] est_beta,
	output logic [31:0] phase_u,
	output logic [31:0] phase_v,
	output logic [31:0] phase_w,
	output logic [16:0] confidence
);

	// truncate-toward-zero arithmetic shift
	function automatic logic signed [MUL_PW-1:0] tsr(input logic signed [MUL_PW-1:0] v,
			input logic [5:0] k);
		logic signed [MUL_PW-1:0] bias;
		bias = v[MUL_PW-1] ? ((MUL_PW'(1) <<< k) - MUL_PW'(1)) : '0;
		return (v + bias) >>> k;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [MUL_PW-1:0] v);
		if (v > $signed(MUL_PW'(32'h7FFF_FFFF)))
			return 32'h7FFF_FFFF;
		else if (v < -$signed(MUL_PW'(33'h0_8000_0000)))
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [MUL_PW-1:0] sx(input logic [31:0] v);
		return $signed({{(MUL_PW-32){v[31]}}, v});
	endfunction

	mco_state_t state_q, state_nx;

	// configuration
	logic [23:0] res_q, ind_q, flux_q;
	logic [16:0] cgain_q;
	logic [30:0] egain_q;

	// observer state
	logic [31:0] cur_a_q, cur_b_q, emf_a_q, emf_b_q;
	logic [16:0] trust_q;

	// latched item
	logic [31:0] va_q, vb_q, mu_q, mv_q;
	logic [15:0] ang_q;
	logic [19:0] dt_q;

	// working registers
	logic [30:0] x_q, x2_q;
	logic [31:0] p_q;
	logic [1:0]  quad_q;
	logic [1:0]  pcnt_q;
	logic        sel_cos_q;
	logic [31:0] sin_q, cos_q, ea_q, eb_q;
	logic        axis_q;
	logic [40:0] diff_q;
	logic [MUL_PW-1:0] acc_q;
	logic [32:0] err_a_q, err_b_q;
	logic [31:0] pv_q, pw_q;

	// output register
	logic        out_valid_q;
	logic [31:0] est_a_q, est_b_q, ph_v_q, ph_w_q;
	logic [16:0] conf_q;

	logic signed [MUL_OPW-1:0] mul_a, mul_b;
	logic signed [MUL_PW-1:0]  prod;
	logic                      div_start, div_done;
	logic signed [DIV_NW:0]    div_quot;
	logic signed [MUL_PW-1:0]  div_num;

	logic accept, load_out, predict_on;
	logic [15:0] sin_ang;
	logic [14:0] sin_r;
	logic [31:0] sin_mag;
	logic [31:0] sin_coef;
	logic signed [MUL_PW-1:0] pr_sum, ic_a, mu_x, mv_x, mb_x;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = state_q != ST_IDLE;
	assign load_out   = state_q == ST_DONE && (!out_valid_q || !out_stall);
	assign predict_on = step_ns != '0 && ind_q != '0;

	mco_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign div_num = acc_q + prod;

	mco_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num[DIV_NW:0]),
		.den    (ind_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FN_PREDICT && predict_on)
						state_nx = (flux_q != '0) ? ST_SIN_PREP : ST_PR_RI;
					else if (func == FN_CORRECT)
						state_nx = ST_CO;
					else
						state_nx = ST_IC;
				end
			end
			ST_SIN_PREP: state_nx = ST_SIN_X2;
			ST_SIN_X2:   state_nx = ST_SIN_X2W;
			ST_SIN_X2W:  state_nx = ST_SIN_PM;
			ST_SIN_PM:   state_nx = ST_SIN_PW;
			ST_SIN_PW:   state_nx = (pcnt_q == 2'd3) ? ST_SIN_FX : ST_SIN_PM;
			ST_SIN_FX:   state_nx = ST_SIN_FW;
			ST_SIN_FW:   state_nx = sel_cos_q ? ST_EMF : ST_SIN_PREP;
			ST_EMF:      state_nx = ST_EMF_A;
			ST_EMF_A:    state_nx = ST_EMF_B;
			ST_EMF_B:    state_nx = ST_PR_RI;
			ST_PR_RI:    state_nx = ST_PR_DF;
			ST_PR_DF:    state_nx = ST_PR_M1;
			ST_PR_M1:    state_nx = ST_PR_M2;
			ST_PR_M2:    state_nx = ST_PR_M3;
			ST_PR_M3:    state_nx = ST_PR_DIV;
			ST_PR_DIV: begin
				if (div_done)
					state_nx = axis_q ? ST_DECAY : ST_PR_RI;
			end
			ST_DECAY:    state_nx = ST_DECAY_W;
			ST_DECAY_W:  state_nx = ST_IC;
			ST_CO:       state_nx = ST_CO_MB;
			ST_CO_MB:    state_nx = ST_CO_CA;
			ST_CO_CA:    state_nx = ST_CO_CB;
			ST_CO_CB:    state_nx = ST_CO_EA;
			ST_CO_EA:    state_nx = ST_CO_EB;
			ST_CO_EB:    state_nx = ST_CO_END;
			ST_CO_END:   state_nx = ST_IC;
			ST_IC:       state_nx = ST_IC_W;
			ST_IC_W:     state_nx = ST_DONE;
			ST_DONE: begin
				if (load_out)
					state_nx = ST_IDLE;
			end
			default:     state_nx = ST_IDLE;
		endcase
	end

	// multiplier operands and divider start
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		case (state_q)
			ST_SIN_X2: begin
				mul_a = $signed(MUL_OPW'(x_q));
				mul_b = $signed(MUL_OPW'(x_q));
			end
			ST_SIN_PM: begin
				mul_a = $signed(MUL_OPW'(p_q));
				mul_b = $signed(MUL_OPW'(x2_q));
			end
			ST_SIN_FX: begin
				mul_a = $signed(MUL_OPW'(p_q));
				mul_b = $signed(MUL_OPW'(x_q));
			end
			ST_EMF: begin
				mul_a = $signed(MUL_OPW'(flux_q));
				mul_b = $signed({{(MUL_OPW-32){sin_q[31]}}, sin_q});
			end
			ST_EMF_A: begin
				mul_a = $signed(MUL_OPW'(flux_q));
				mul_b = $signed({{(MUL_OPW-32){cos_q[31]}}, cos_q});
			end
			ST_PR_RI: begin
				mul_a = $signed(MUL_OPW'(res_q));
				mul_b = axis_q ? $signed({{(MUL_OPW-32){cur_b_q[31]}}, cur_b_q})
				               : $signed({{(MUL_OPW-32){cur_a_q[31]}}, cur_a_q});
			end
			ST_PR_M1: begin
				// upper part of the difference, signed
				mul_a = $signed({{(MUL_OPW-21){diff_q[40]}}, diff_q[40:20]});
				mul_b = $signed(MUL_OPW'(dt_q));
			end
			ST_PR_M2: begin
				mul_a = $signed(MUL_OPW'(diff_q[19:0]));
				mul_b = $signed(MUL_OPW'(dt_q));
			end
			ST_PR_M3: div_start = 1'b1;
			ST_DECAY: begin
				mul_a = $signed(MUL_OPW'(trust_q));
				mul_b = $signed(MUL_OPW'(DECAY_Q16));
			end
			ST_CO: begin
				mul_a = MUL_OPW'(mu_x + (mv_x <<< 1));
				mul_b = $signed(MUL_OPW'(INV_SQRT3_Q30));
			end
			ST_CO_CA: begin
				mul_a = $signed(MUL_OPW'(cgain_q));
				mul_b = $signed({err_a_q[32], err_a_q});
			end
			ST_CO_CB: begin
				mul_a = $signed(MUL_OPW'(cgain_q));
				mul_b = $signed({err_b_q[32], err_b_q});
			end
			ST_CO_EA: begin
				mul_a = $signed(MUL_OPW'(egain_q));
				mul_b = $signed({err_a_q[32], err_a_q});
			end
			ST_CO_EB: begin
				mul_a = $signed(MUL_OPW'(egain_q));
				mul_b = $signed({err_b_q[32], err_b_q});
			end
			ST_IC: begin
				mul_a = $signed({{(MUL_OPW-32){cur_b_q[31]}}, cur_b_q});
				mul_b = $signed(MUL_OPW'(HALF_SQRT3_Q30));
			end
			default: begin
				mul_a     = '0;
				mul_b     = '0;
				div_start = 1'b0;
			end
		endcase
	end

	// sine helpers: quadrant fold and series coefficient
	assign sin_ang = sel_cos_q ? ang_q + 16'h4000 : ang_q;
	assign sin_r   = sin_ang[14] ? 15'h4000 - {1'b0, sin_ang[13:0]} : {1'b0, sin_ang[13:0]};
	assign sin_mag = (prod[61:30] > 32'(Q30_ONE)) ? 32'(Q30_ONE) : prod[61:30];

	always_comb begin
		case (pcnt_q)
			2'd0:    sin_coef = SIN_C1;
			2'd1:    sin_coef = SIN_C2;
			2'd2:    sin_coef = SIN_C3;
			default: sin_coef = SIN_C4;
		endcase
	end

	assign mu_x   = sx(mu_q);
	assign mv_x   = sx(mv_q);
	assign mb_x   = sx(sat32(tsr(prod, 6'd30)));
	assign pr_sum = sx(axis_q ? cur_b_q : cur_a_q) + div_quot;
	assign ic_a   = sx(cur_a_q) <<< 29;

	// control and observer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			res_q       <= '0;
			ind_q       <= '0;
			flux_q      <= '0;
			cgain_q     <= '0;
			egain_q     <= '0;
			cur_a_q     <= '0;
			cur_b_q     <= '0;
			emf_a_q     <= '0;
			emf_b_q     <= '0;
			trust_q     <= '0;
		end else begin
			state_q <= state_nx;

			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (cfg_write) begin
				case (cfg_index)
					REG_RESISTANCE: res_q   <= cfg_data[23:0];
					REG_INDUCTANCE: ind_q   <= cfg_data[23:0];
					REG_FLUX:       flux_q  <= cfg_data[23:0];
					REG_CUR_GAIN:   cgain_q <= cfg_data[16:0];
					REG_EMF_GAIN:   egain_q <= cfg_data;
					default:        ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && func == FN_CLEAR) begin
						cur_a_q <= '0;
						cur_b_q <= '0;
						emf_a_q <= '0;
						emf_b_q <= '0;
						trust_q <= '0;
					end
				end
				ST_PR_DIV: begin
					if (div_done) begin
						if (axis_q)
							cur_b_q <= sat32(pr_sum);
						else
							cur_a_q <= sat32(pr_sum);
					end
				end
				ST_DECAY_W: trust_q <= prod[32:16];
				ST_CO_CB:   cur_a_q <= sat32(sx(cur_a_q) + tsr(prod, 6'd16));
				ST_CO_EA:   cur_b_q <= sat32(sx(cur_b_q) + tsr(prod, 6'd16));
				ST_CO_EB:   emf_a_q <= sat32(sx(emf_a_q) + tsr(prod, 6'd16));
				ST_CO_END: begin
					emf_b_q <= sat32(sx(emf_b_q) + tsr(prod, 6'd16));
					trust_q <= 17'h1_0000;
				end
				default: ;
			endcase
		end
	end

	// working registers and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					va_q      <= volt_alpha;
					vb_q      <= volt_beta;
					ang_q     <= angle;
					dt_q      <= step_ns;
					mu_q      <= meas_u;
					mv_q      <= meas_v;
					sel_cos_q <= 1'b0;
					axis_q    <= 1'b0;
					// stored estimate stands in when the flux is uncalibrated
					ea_q      <= emf_a_q;
					eb_q      <= emf_b_q;
				end
			end
			ST_SIN_PREP: begin
				x_q    <= {sin_r, 16'd0};
				quad_q <= sin_ang[15:14];
			end
			ST_SIN_X2W: begin
				x2_q   <= prod[60:30];
				p_q    <= SIN_C0;
				pcnt_q <= 2'd0;
			end
			ST_SIN_PW: begin
				p_q    <= sin_coef - prod[61:30];
				pcnt_q <= pcnt_q + 1'b1;
			end
			ST_SIN_FW: begin
				if (sel_cos_q)
					cos_q <= quad_q[1] ? -sin_mag : sin_mag;
				else
					sin_q <= quad_q[1] ? -sin_mag : sin_mag;
				sel_cos_q <= 1'b1;
			end
			ST_EMF_A:   ea_q <= 32'(-tsr(prod, 6'd38));
			ST_EMF_B:   eb_q <= 32'(tsr(prod, 6'd38));
			ST_PR_DF: begin
				diff_q <= 41'(sx(axis_q ? vb_q : va_q) - tsr(prod, 6'd16)
					- sx(axis_q ? eb_q : ea_q));
			end
			ST_PR_M2:   acc_q <= prod <<< 20;
			ST_PR_DIV: begin
				if (div_done)
					axis_q <= 1'b1;
			end
			ST_CO_MB: begin
				err_a_q <= 33'(mu_x - sx(cur_a_q));
				err_b_q <= 33'(mb_x - sx(cur_b_q));
			end
			ST_IC_W: begin
				pv_q <= sat32(tsr(prod - ic_a, 6'd30));
				pw_q <= sat32(tsr(-ic_a - prod, 6'd30));
			end
			default: ;
		endcase

		if (load_out) begin
			est_a_q <= cur_a_q;
			est_b_q <= cur_b_q;
			ph_v_q  <= pv_q;
			ph_w_q  <= pw_q;
			conf_q  <= trust_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign est_alpha  = est_a_q;
	assign est_beta   = est_b_q;
	assign phase_u    = est_a_q;
	assign phase_v    = ph_v_q;
	assign phase_w    = ph_w_q;
	assign confidence = conf_q;

endmodule

// ----- bench/mco_checker.sv -----
// Checker for the motor current observer: watches both channels and the write port,
// predicts each result and compares it. Depends on mco_pkg.
`timescale 1ns / 100ps
module mco_checker import mco_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] volt_alpha,
	input  logic [31:0] volt_beta,
	input  logic [15:0] angle,
	input  logic [19:0] step_ns,
	input  logic [31:0] meas_u,
	input  logic [31:0] meas_v,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] est_alpha,
	input  logic [31:0] est_beta,
	input  logic [31:0] phase_u,
	input  logic [31:0] phase_v,
	input  logic [31:0] phase_w,
	input  logic [16:0] confidence,
	output int          fail_count,
	output int          awaiting
);

	typedef logic signed [95:0] wide_t;

	typedef struct {
		logic [31:0] est_alpha;
		logic [31:0] est_beta;
		logic [31:0] phase_u;
		logic [31:0] phase_v;
		logic [31:0] phase_w;
		logic [16:0] confidence;
	} estimate_t;

	estimate_t   estimate_q[$];
	logic [23:0] r_ohm, l_nh, flux;
	logic [16:0] k_cur;
	logic [30:0] k_emf;
	logic signed [31:0] i_a, i_b, e_a, e_b;
	logic [16:0] trust_lvl;

	function automatic wide_t clip32(wide_t v);
		wide_t hi, lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// sin(pi/2 * x), x and result in Q30
	function automatic wide_t quarter_wave(wide_t x);
		wide_t x2, p, c1, c2, c3, c4, one;
		x2 = (x * x) >>> 30;
		p = wide_t'(SIN_C0);
		c1 = wide_t'(SIN_C1);
		c2 = wide_t'(SIN_C2);
		c3 = wide_t'(SIN_C3);
		c4 = wide_t'(SIN_C4);
		one = wide_t'(Q30_ONE);
		p = c1 - ((p * x2) >>> 30);
		p = c2 - ((p * x2) >>> 30);
		p = c3 - ((p * x2) >>> 30);
		p = c4 - ((p * x2) >>> 30);
		p = (p * x) >>> 30;
		return (p > one) ? one : p;
	endfunction

	function automatic wide_t angle_sine(logic [15:0] a);
		wide_t r, s;
		r = wide_t'(a[13:0]);
		if (a[14]) s = quarter_wave((wide_t'(16384) - r) <<< 16);
		else s = quarter_wave(r <<< 16);
		return a[15] ? -s : s;
	endfunction

	function automatic wide_t euler_axis(wide_t i, wide_t v, wide_t e, wide_t dt);
		wide_t diff;
		diff = v - (wide_t'(r_ohm) * i) / 65536 - e;
		return clip32(i + (diff * dt) / wide_t'(l_nh));
	endfunction

	// advance the observer state by one transaction and return what it reports
	function automatic estimate_t observe(logic [1:0] fn, logic [31:0] va, logic [31:0] vb,
			logic [15:0] ang, logic [19:0] dt, logic [31:0] mu, logic [31:0] mv);
		wide_t ea, eb, u, v, mb, da, db, a, b, half, hs3, one, pv, pw;
		estimate_t res;
		one = wide_t'(Q30_ONE);
		half = one / 2;
		hs3 = wide_t'(HALF_SQRT3_Q30);
		case (fn)
			FN_PREDICT: begin
				if (dt != 0 && l_nh != 0) begin
					ea = wide_t'(e_a);
					eb = wide_t'(e_b);
					if (flux != 0) begin
						ea = -((wide_t'(flux) * angle_sine(ang)) / (wide_t'(1) <<< 38));
						eb = (wide_t'(flux) * angle_sine(ang + 16'h4000)) / (wide_t'(1) <<< 38);
					end
					i_a = 32'(euler_axis(wide_t'(i_a), wide_t'($signed(va)), ea, wide_t'(dt)));
					i_b = 32'(euler_axis(wide_t'(i_b), wide_t'($signed(vb)), eb, wide_t'(dt)));
					trust_lvl = 17'((wide_t'(trust_lvl) * wide_t'(DECAY_Q16)) >>> 16);
				end
			end
			FN_CORRECT: begin
				u = wide_t'($signed(mu));
				v = wide_t'($signed(mv));
				mb = clip32(((u + 2 * v) * wide_t'(INV_SQRT3_Q30)) / one);
				da = u - wide_t'(i_a);
				db = mb - wide_t'(i_b);
				i_a = 32'(clip32(wide_t'(i_a) + (wide_t'(k_cur) * da) / 65536));
				i_b = 32'(clip32(wide_t'(i_b) + (wide_t'(k_cur) * db) / 65536));
				e_a = 32'(clip32(wide_t'(e_a) + (wide_t'(k_emf) * da) / 65536));
				e_b = 32'(clip32(wide_t'(e_b) + (wide_t'(k_emf) * db) / 65536));
				trust_lvl = 17'h10000;
			end
			FN_CLEAR: begin
				i_a = 0; i_b = 0; e_a = 0; e_b = 0; trust_lvl = 0;
			end
			default: ;
		endcase
		a = wide_t'(i_a);
		b = wide_t'(i_b);
		pv = clip32((-a * half + b * hs3) / one);
		pw = clip32((-a * half - b * hs3) / one);
		res.est_alpha = i_a;
		res.est_beta = i_b;
		res.phase_u = i_a;
		res.phase_v = pv[31:0];
		res.phase_w = pw[31:0];
		res.confidence = trust_lvl;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		estimate_t want;
		if (!arst_n) begin
			r_ohm = 0; l_nh = 0; flux = 0; k_cur = 0; k_emf = 0;
			i_a = 0; i_b = 0; e_a = 0; e_b = 0; trust_lvl = 0;
			estimate_q.delete();
			fail_count = 0;
			awaiting = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_RESISTANCE: r_ohm = cfg_data[23:0];
					REG_INDUCTANCE: l_nh = cfg_data[23:0];
					REG_FLUX:       flux = cfg_data[23:0];
					REG_CUR_GAIN:   k_cur = cfg_data[16:0];
					REG_EMF_GAIN:   k_emf = cfg_data[30:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (estimate_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result with nothing outstanding", $time);
				end else begin
					want = estimate_q.pop_front();
					if (want.est_alpha !== est_alpha || want.est_beta !== est_beta ||
							want.phase_u !== phase_u || want.phase_v !== phase_v ||
							want.phase_w !== phase_w || want.confidence !== confidence) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch exp %h %h %h %h %h %h got %h %h %h %h %h %h",
								$time, want.est_alpha, want.est_beta, want.phase_u,
								want.phase_v, want.phase_w, want.confidence, est_alpha,
								est_beta, phase_u, phase_v, phase_w, confidence);
					end
				end
			end
			if (in_valid && !in_stall)
				estimate_q.push_back(observe(func, volt_alpha, volt_beta, angle, step_ns,
					meas_u, meas_v));
			awaiting = estimate_q.size();
		end
	end

endmodule

// ----- bench/motor_current_observer_unit_test.sv -----
// Top of the motor current observer bench: clock, reset, register writes and stimulus.
// Depends on mco_pkg, motor_current_observer_unit and mco_checker.
`timescale 1ns / 100ps
module motor_current_observer_unit_test;
	import mco_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 200;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [30:0] cfg_data;
	logic        in_valid, in_stall;
	logic [1:0]  func;
	logic [31:0] volt_alpha, volt_beta, meas_u, meas_v;
	logic [15:0] angle;
	logic [19:0] step_ns;
	logic        out_valid, out_stall;
	logic [31:0] est_alpha, est_beta, phase_u, phase_v, phase_w;
	logic [16:0] confidence;
	int          fail_count, awaiting;
	int          send_idle_pct, recv_stall_pct;
	int          cycle_count;

	motor_current_observer_unit dut (.*);

	mco_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// random backpressure on the result channel, changed on falling edges
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	// watchdog: end the run if the block hangs
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// write one register on the next falling edge; the block latches it on the rising edge
	task automatic write_reg(logic [2:0] idx, logic [30:0] val);
		@(negedge clk);
		cfg_write = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 0;
	endtask

	// hold off until every outstanding transaction has returned
	task automatic drain();
		while (awaiting != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic load_motor(logic [23:0] r, logic [23:0] l, logic [23:0] fl,
			logic [16:0] kc, logic [30:0] ke);
		drain();
		write_reg(REG_RESISTANCE, r);
		write_reg(REG_INDUCTANCE, l);
		write_reg(REG_FLUX, fl);
		write_reg(REG_CUR_GAIN, kc);
		write_reg(REG_EMF_GAIN, ke);
	endtask

	// present one transaction, wait until it is taken, then drop valid
	task automatic issue(logic [1:0] fn, logic [31:0] va, logic [31:0] vb, logic [15:0] ang,
			logic [19:0] dt, logic [31:0] mu, logic [31:0] mv);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		func = fn;
		volt_alpha = va;
		volt_beta = vb;
		angle = ang;
		step_ns = dt;
		meas_u = mu;
		meas_v = mv;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 0;
	endtask

	// mostly plausible operating points with random content, some raw noise
	task automatic random_item();
		logic [1:0] fn;
		int pick;
		pick = $urandom_range(99);
		if (pick < 45) fn = FN_PREDICT;
		else if (pick < 88) fn = FN_CORRECT;
		else if (pick < 95) fn = FN_CLEAR;
		else fn = 2'd3;
		if ($urandom_range(99) < 70)
			issue(fn, $signed($urandom_range(8388608)) - 4194304,
				$signed($urandom_range(8388608)) - 4194304, $urandom_range(65535),
				$urandom_range(100000), $signed($urandom_range(2097152)) - 1048576,
				$signed($urandom_range(2097152)) - 1048576);
		else
			issue(fn, $urandom, $urandom, $urandom_range(65535), $urandom_range(1000000),
				$urandom, $urandom);
	endtask

	task automatic random_motor(int sel);
		case (sel)
			0: load_motor(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 17'h10000, 31'h7FFFFFFF);
			1: load_motor(0, 1, 0, 0, 0);
			default: load_motor($urandom_range(300000), $urandom_range(2000000, 1),
				($urandom_range(3) == 0) ? 24'd0 : 24'($urandom),
				$urandom_range(65536), $urandom_range(200000));
		endcase
	endtask

	initial begin
		arst_n = 0;
		cfg_write = 0;
		cfg_index = 0;
		cfg_data = 0;
		in_valid = 0;
		func = FN_PREDICT;
		volt_alpha = 0;
		volt_beta = 0;
		angle = 0;
		step_ns = 0;
		meas_u = 0;
		meas_v = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// zero inductance after reset: predict must leave the state alone
		issue(FN_PREDICT, 32'h7FFFFFFF, 32'h80000000, 16'h1234, 20'd1000, 0, 0);
		issue(2'd3, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 20'd1000000, 32'h7FFFFFFF, 0);
		// correct at full measurement extremes
		load_motor(24'd65536, 24'd100000, 24'd0, 17'h10000, 31'h7FFFFFFF);
		issue(FN_CORRECT, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF);
		issue(FN_CORRECT, 0, 0, 0, 0, 32'h80000000, 32'h80000000);
		issue(FN_CORRECT, 0, 0, 0, 0, 32'h00010000, 32'hFFFF0000);
		// stored back-EMF path: zero step, then a short and a full step
		issue(FN_PREDICT, 32'h00050000, 32'hFFFB0000, 16'h0000, 20'd0, 0, 0);
		issue(FN_PREDICT, 32'h00050000, 32'hFFFB0000, 16'h0000, 20'd1000, 0, 0);
		issue(FN_PREDICT, 32'h7FFFFFFF, 32'h80000000, 16'h0000, 20'd1000000, 0, 0);
		issue(FN_CLEAR, 0, 0, 0, 0, 0, 0);
		// flux-derived back-EMF at the quadrant boundaries
		load_motor(24'hFFFFFF, 24'd200000, 24'hFFFFFF, 17'd32768, 31'd65536);
		issue(FN_CORRECT, 0, 0, 0, 0, 32'h00030000, 32'h00010000);
		issue(FN_PREDICT, 32'h00100000, 32'h00100000, 16'h0000, 20'd5000, 0, 0);
		issue(FN_PREDICT, 32'h00100000, 32'h00100000, 16'h4000, 20'd5000, 0, 0);
		issue(FN_PREDICT, 32'h00100000, 32'h00100000, 16'h8000, 20'd5000, 0, 0);
		issue(FN_PREDICT, 32'h00100000, 32'h00100000, 16'hC000, 20'd5000, 0, 0);
		issue(FN_PREDICT, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 20'd1000000, 0, 0);
		issue(2'd3, 0, 0, 0, 0, 0, 0);
		issue(FN_CLEAR, 0, 0, 0, 0, 0, 0);

		// three idling phases, each under a few register settings
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 83 : 0;
			recv_stall_pct = (ph == 0) ? 83 : (ph == 1) ? 6 : 0;
			for (int k = 0; k < 3; k++) begin
				random_motor((ph + k) % 3 == 0 ? k : 2);
				for (int n = 0; n < 155; n++) random_item();
			end
		end
		@(negedge clk);
		in_valid = 0;

		while (awaiting != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && awaiting == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/mco_pkg.sv
rtl/core/mco_mul.sv
rtl/core/mco_div.sv
rtl/core/motor_current_observer_unit.sv
bench/mco_checker.sv
bench/motor_current_observer_unit_test.sv
